// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge except while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/csvft_pkg.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Character codes, parser modes, controller states and the command and
// status bundles shared by the tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package csvft_pkg;

   localparam int WS_DEPTH_DEFAULT = 32;

   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;

   typedef enum logic [2:0] {
      MODE_LINE  = 3'd0,
      MODE_SKIP  = 3'd1,
      MODE_UNQ   = 3'd2,
      MODE_QUO   = 3'd3,
      MODE_QSEEN = 3'd4,
      MODE_DISC  = 3'd5
   } mode_type;

   typedef enum logic {
      ST_ACCEPT = 1'b0,
      ST_FLUSH  = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic needs_flush;
      logic flush_last;
   } status_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      return (c == CHAR_COMMA) || (c == CHAR_NEWLINE);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/csvft_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module csvft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/csvft_ctrl.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer controller
// Decides when an input transaction is taken and sequences the replay of
// buffered whitespace ahead of the byte that ends it.
// ----------------------------------------------------------------------------
`default_nettype none

module csvft_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  csvft_pkg::status_type  status,
   output csvft_pkg::cmd_type     cmd
);

   import csvft_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.emit   = 1'b0;
      case (state_ff)
         ST_ACCEPT: begin
            req_ready  = status.slot_free;
            cmd.accept = req_valid && status.slot_free;
            if (cmd.accept && status.needs_flush) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            cmd.emit = status.slot_free;
            if (cmd.emit && status.flush_last) begin
               state_in = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/csvft_dpath.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer datapath
// Parser mode, whitespace buffer with its fill count, overflow flag and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module csvft_dpath #(
   parameter int WS_DEPTH = csvft_pkg::WS_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  csvft_pkg::cmd_type     cmd,
   output csvft_pkg::status_type  status,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_stream_end,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_has_byte,
   output logic                   rsp_field_end,
   output logic                   rsp_ws_overflow,
   output logic                   rsp_last
);

   import csvft_pkg::*;

   localparam int CNT_W     = $clog2(WS_DEPTH + 1);
   localparam int AW        = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
   localparam int RAM_DEPTH = 1 << AW;

   mode_type         mode_ff, mode_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [7:0]       held_ff, held_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_has_ff, rsp_has_in;
   logic             rsp_fend_ff, rsp_fend_in;
   logic             rsp_ovf_ff, rsp_ovf_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [AW-1:0]    rd_addr;
   logic [7:0]       rd_data;

   logic             c_ws, c_delim, c_quote;
   logic             do_close;
   logic             res_load;
   logic [7:0]       res_byte;
   logic             res_has, res_fend, res_last;
   logic [CNT_W-1:0] idx_next;
   mode_type         close_mode;

   csvft_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_ws_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_in_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      c_ws       = is_ws(req_in_byte);
      c_delim    = is_delim(req_in_byte);
      c_quote    = (req_in_byte == CHAR_QUOTE);
      close_mode = (req_in_byte == CHAR_COMMA) ? MODE_SKIP : MODE_LINE;
      idx_next   = idx_ff + 1'b1;

      status.slot_free   = !rsp_valid_ff || rsp_ready;
      status.needs_flush = !req_stream_end && (mode_ff == MODE_UNQ) && !c_delim &&
                           !c_ws && (count_ff != '0);
      status.flush_last  = (idx_ff == count_ff);

      mode_in  = mode_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      idx_in   = idx_ff;
      held_in  = held_ff;
      wr_en    = 1'b0;
      wr_addr  = count_ff[AW-1:0];
      rd_addr  = idx_ff[AW-1:0];
      do_close = 1'b0;
      res_load = 1'b0;
      res_byte = '0;
      res_has  = 1'b0;
      res_fend = 1'b0;
      res_last = 1'b1;

      if (cmd.accept) begin
         if (req_stream_end) begin
            case (mode_ff)
               MODE_SKIP, MODE_UNQ, MODE_QUO, MODE_QSEEN, MODE_DISC: begin
                  res_load = 1'b1;
                  res_fend = 1'b1;
               end
               default: begin
               end
            endcase
            mode_in  = MODE_LINE;
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            case (mode_ff)
               MODE_UNQ: begin
                  if (c_delim) begin
                     do_close = 1'b1;
                  end else if (c_ws) begin
                     if (count_ff < CNT_W'(WS_DEPTH)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end else if (count_ff != '0) begin
                     held_in = req_in_byte;
                     idx_in  = '0;
                     rd_addr = '0;
                  end else begin
                     res_load = 1'b1;
                     res_has  = 1'b1;
                     res_byte = req_in_byte;
                  end
               end
               MODE_QUO: begin
                  if (c_quote) begin
                     mode_in = MODE_QSEEN;
                  end else begin
                     res_load = 1'b1;
                     res_has  = 1'b1;
                     res_byte = req_in_byte;
                  end
               end
               MODE_QSEEN: begin
                  if (c_quote) begin
                     res_load = 1'b1;
                     res_has  = 1'b1;
                     res_byte = req_in_byte;
                     mode_in  = MODE_QUO;
                  end else if (c_delim) begin
                     do_close = 1'b1;
                  end else begin
                     mode_in = MODE_DISC;
                  end
               end
               MODE_DISC: begin
                  if (c_delim) begin
                     do_close = 1'b1;
                  end
               end
               default: begin
                  if (c_ws) begin
                     mode_in = (mode_ff == MODE_SKIP) ? MODE_SKIP : MODE_LINE;
                  end else if (c_delim) begin
                     do_close = 1'b1;
                  end else if (c_quote) begin
                     mode_in = MODE_QUO;
                  end else begin
                     res_load = 1'b1;
                     res_has  = 1'b1;
                     res_byte = req_in_byte;
                     mode_in  = MODE_UNQ;
                  end
               end
            endcase
         end
      end else if (cmd.emit) begin
         res_load = 1'b1;
         res_has  = 1'b1;
         if (status.flush_last) begin
            res_byte = held_ff;
            count_in = '0;
         end else begin
            res_byte = rd_data;
            res_last = 1'b0;
            idx_in   = idx_next;
            rd_addr  = idx_next[AW-1:0];
         end
      end

      if (do_close) begin
         res_load = 1'b1;
         res_fend = 1'b1;
         mode_in  = close_mode;
         count_in = '0;
         ovf_in   = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_fend_in  = rsp_fend_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = res_byte;
         rsp_has_in   = res_has;
         rsp_fend_in  = res_fend;
         rsp_ovf_in   = ovf_ff;
         rsp_last_in  = res_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_LINE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      held_ff     <= held_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_fend_ff <= rsp_fend_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_has_byte    = rsp_has_ff;
   assign rsp_field_end   = rsp_fend_ff;
   assign rsp_ws_overflow = rsp_ovf_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/csv_field_tokenizer.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer
// The req channel takes one CSV byte per transaction, or an end-of-stream
// mark when req_stream_end is high. The rsp channel returns the text of each
// field one byte per transaction, then a transaction with rsp_field_end set.
// rsp_last marks the final response caused by one request; a request may
// cause none. Leading blanks are skipped, trailing blanks dropped, quoted
// fields keep commas and newlines and collapse doubled quotes.
// Outside a blank replay, a response appears in the result register the cycle
// after its request is taken, so one byte per cycle is sustained while the
// receiver keeps up. A byte that ends a run of buffered blanks is taken in a
// step that starts reading the blank buffer RAM; then each buffered blank and
// the byte itself are sent, and req_ready stays low until the byte is out.
// A new request is taken while the last response waits, as long as the
// result register is being emptied in the same cycle; a stalled receiver
// holds req_ready low. Reset returns the parser to the start of a line with
// an empty blank buffer and no pending response; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_tokenizer #(
   parameter int WS_DEPTH = csvft_pkg::WS_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_stream_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_field_end,
   output logic       rsp_ws_overflow,
   output logic       rsp_last
);

   import csvft_pkg::*;

   cmd_type    cmd;
   status_type status;

   csvft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   csvft_dpath #(
      .WS_DEPTH (WS_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_in_byte     (req_in_byte),
      .req_stream_end  (req_stream_end),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_field_end   (rsp_field_end),
      .rsp_ws_overflow (rsp_ws_overflow),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// ===== rtl/core/csvft_checker.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module csvft_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_has_byte,
   input logic       rsp_field_end,
   input logic       rsp_ws_overflow,
   input logic       rsp_last
);

   logic        rsp_stall;
   logic        rsp_fend;
   logic        rsp_kind_ok;
   logic [12:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_fend    = rsp_valid && rsp_field_end;
   assign rsp_kind_ok = rsp_has_byte ^ rsp_field_end;
   assign rsp_payload = {rsp_valid, rsp_out_byte, rsp_has_byte, rsp_field_end,
                         rsp_ws_overflow, rsp_last};

   `ASSERT_ALWAYS(a_idle_after_reset, clock, $past(reset) |-> !rsp_valid, "valid after reset")

   `ASSERT_RST(a_rsp_hold, clock, reset, rsp_stall |=> $stable(rsp_payload), "response changed")

   `ASSERT_RST(a_kind, clock, reset, rsp_valid |-> rsp_kind_ok, "response kind is ambiguous")

   `ASSERT_RST(a_fend_last, clock, reset, rsp_fend |-> rsp_last, "field end not last")

   `ASSERT_RST(a_fend_zero, clock, reset, rsp_fend |-> (rsp_out_byte == '0), "byte on field end")

endmodule

bind csv_field_tokenizer csvft_checker u_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer testbench
// Streams CSV text into the tokenizer and checks every response against a
// behavioral tokenizer kept in step with the accepted requests. Directed
// cases cover empty fields, blank handling, quoted fields and end of stream.
// Random records then run under several handshake idling mixes, and a long
// response stall drives the block into input backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   import csvft_pkg::*;

   localparam int WS_DEPTH    = WS_DEPTH_DEFAULT;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 2 * WS_DEPTH;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       field_end;
      logic       ws_overflow;
      logic       last;
   } token_type;

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte    = 8'h00;
   logic       req_stream_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_byte;
   logic       rsp_field_end;
   logic       rsp_ws_overflow;
   logic       rsp_last;

   mode_type   cur_mode      = MODE_LINE;
   logic [7:0] blank_buf [WS_DEPTH];
   int         blank_cnt     = 0;
   logic       dropped_blank = 1'b0;

   token_type  step_tokens[$];
   token_type  expected_tokens[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;

   int mismatches      = 0;
   int requests_sent   = 0;
   int responses_seen  = 0;
   int fields_closed   = 0;
   int overflow_fields = 0;

   csv_field_tokenizer #(
      .WS_DEPTH(WS_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_stream_end (req_stream_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_field_end  (rsp_field_end),
      .rsp_ws_overflow(rsp_ws_overflow),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void emit_token(input logic [7:0] b, input logic has,
                                      input logic fend);
      token_type t;
      t.out_byte    = b;
      t.has_byte    = has;
      t.field_end   = fend;
      t.ws_overflow = dropped_blank;
      t.last        = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function automatic void end_field(input mode_type next_mode);
      emit_token(8'h00, 1'b0, 1'b1);
      blank_cnt     = 0;
      dropped_blank = 1'b0;
      cur_mode      = next_mode;
   endfunction

   function automatic void tokenize(input logic [7:0] b, input logic e);
      logic     blank;
      logic     sep;
      mode_type after_sep;
      int       i;
      blank     = (b == CHAR_SPACE) || (b == CHAR_TAB);
      sep       = (b == CHAR_COMMA) || (b == CHAR_NEWLINE);
      after_sep = (b == CHAR_COMMA) ? MODE_SKIP : MODE_LINE;
      step_tokens.delete();
      if (e) begin
         if (cur_mode != MODE_LINE) emit_token(8'h00, 1'b0, 1'b1);
         cur_mode      = MODE_LINE;
         blank_cnt     = 0;
         dropped_blank = 1'b0;
      end else begin
         case (cur_mode)
            MODE_UNQ: begin
               if (sep) begin
                  end_field(after_sep);
               end else if (blank) begin
                  if (blank_cnt < WS_DEPTH) begin
                     blank_buf[blank_cnt] = b;
                     blank_cnt++;
                  end else begin
                     dropped_blank = 1'b1;
                  end
               end else begin
                  for (i = 0; i < blank_cnt; i++) emit_token(blank_buf[i], 1'b1, 1'b0);
                  blank_cnt = 0;
                  emit_token(b, 1'b1, 1'b0);
               end
            end
            MODE_QUO: begin
               if (b == CHAR_QUOTE) cur_mode = MODE_QSEEN;
               else emit_token(b, 1'b1, 1'b0);
            end
            MODE_QSEEN: begin
               if (b == CHAR_QUOTE) begin
                  emit_token(b, 1'b1, 1'b0);
                  cur_mode = MODE_QUO;
               end else if (sep) begin
                  end_field(after_sep);
               end else begin
                  cur_mode = MODE_DISC;
               end
            end
            MODE_DISC: begin
               if (sep) end_field(after_sep);
            end
            default: begin
               if (sep) begin
                  end_field(after_sep);
               end else if (b == CHAR_QUOTE) begin
                  cur_mode = MODE_QUO;
               end else if (!blank) begin
                  emit_token(b, 1'b1, 1'b0);
                  cur_mode = MODE_UNQ;
               end
            end
         endcase
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[k]) expected_tokens.push_back(step_tokens[k]);
   endfunction

   task automatic send_item(input logic [7:0] b, input logic e);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_stream_end <= e;
      do @(posedge clock); while (!(req_valid && req_ready));
      tokenize(b, e);
      requests_sent++;
   endtask

   function automatic logic [7:0] blank_byte();
      return $urandom_range(1) ? CHAR_SPACE : CHAR_TAB;
   endfunction

   function automatic logic [7:0] text_byte();
      if ($urandom_range(5) == 0) return 8'($urandom);
      return 8'($urandom_range(8'h7E, 8'h21));
   endfunction

   task automatic send_blanks(input int n);
      repeat (n) send_item(blank_byte(), 1'b0);
   endtask

   task automatic send_record();
      int nfields;
      int f;
      int j;
      int n;
      int kind;
      int pick;
      nfields = $urandom_range(4, 1);
      for (f = 0; f < nfields; f++) begin
         if ($urandom_range(3) == 0) send_blanks($urandom_range(3, 1));
         kind = $urandom_range(9);
         if (kind < 5) begin
            n = $urandom_range(6, 1);
            for (j = 0; j < n; j++) begin
               send_item(text_byte(), 1'b0);
               if ($urandom_range(3) == 0) begin
                  if ($urandom_range(9) == 0)
                     send_blanks($urandom_range(WS_DEPTH + 4, WS_DEPTH - 2));
                  else
                     send_blanks($urandom_range(3, 1));
               end
            end
         end else if (kind < 8) begin
            send_item(CHAR_QUOTE, 1'b0);
            n = $urandom_range(6);
            for (j = 0; j < n; j++) begin
               pick = $urandom_range(9);
               if (pick == 0) begin
                  send_item(CHAR_COMMA, 1'b0);
               end else if (pick == 1) begin
                  send_item(CHAR_NEWLINE, 1'b0);
               end else if (pick == 2) begin
                  send_item(CHAR_QUOTE, 1'b0);
                  send_item(CHAR_QUOTE, 1'b0);
               end else begin
                  send_item(text_byte(), 1'b0);
               end
            end
            if ($urandom_range(7) != 0) send_item(CHAR_QUOTE, 1'b0);
            if ($urandom_range(4) == 0) send_item(text_byte(), 1'b0);
         end
         if (f < nfields - 1) send_item(CHAR_COMMA, 1'b0);
      end
      if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b1);
      else send_item(CHAR_NEWLINE, 1'b0);
   endtask

   task automatic test_empty_fields();
      send_item(CHAR_COMMA, 1'b0);
      send_item(CHAR_NEWLINE, 1'b0);
   endtask

   task automatic test_blank_handling();
      send_item(CHAR_SPACE, 1'b0);
      send_item(CHAR_TAB, 1'b0);
      send_item("A", 1'b0);
      send_item(8'h0D, 1'b0);
      send_item(CHAR_SPACE, 1'b0);
      send_item("B", 1'b0);
      send_item(CHAR_SPACE, 1'b0);
      send_item(CHAR_NEWLINE, 1'b0);
   endtask

   task automatic test_quoted_fields();
      send_item(CHAR_QUOTE, 1'b0);
      send_item(CHAR_COMMA, 1'b0);
      send_item(CHAR_NEWLINE, 1'b0);
      send_item(CHAR_QUOTE, 1'b0);
      send_item(CHAR_QUOTE, 1'b0);
      send_item(CHAR_QUOTE, 1'b0);
      send_item("x", 1'b0);
      send_item(CHAR_COMMA, 1'b0);
   endtask

   task automatic test_stream_end();
      send_item(8'hA5, 1'b1);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h5A, 1'b1);
      send_item(CHAR_QUOTE, 1'b0);
      send_item("q", 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(CHAR_SPACE, 1'b0);
      send_item(8'h00, 1'b1);
   endtask

   task automatic test_blank_overflow();
      send_idle_pct  = 14;
      recv_stall_pct = 14;
      send_item("a", 1'b0);
      send_blanks(WS_DEPTH);
      send_item("b", 1'b0);
      send_item(CHAR_COMMA, 1'b0);
      send_item("c", 1'b0);
      send_blanks(WS_DEPTH + 2);
      send_item("d", 1'b0);
      send_item(CHAR_COMMA, 1'b0);
      send_item("e", 1'b0);
      send_blanks(WS_DEPTH + 1);
      send_item(CHAR_NEWLINE, 1'b0);
   endtask

   task automatic test_random_records(input int send_pct, input int recv_pct,
                                      input int budget);
      int stop_at;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      stop_at        = requests_sent + budget;
      while (requests_sent < stop_at) begin
         if ($urandom_range(7) == 0)
            send_item(8'($urandom), $urandom_range(15) == 0);
         else
            send_record();
      end
   endtask

   task automatic test_backpressure();
      int stop_at;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      stop_at        = requests_sent + 30;
      hold_request   = 150;
      while (requests_sent < stop_at) send_record();
   endtask

   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      token_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (rsp_field_end) fields_closed++;
         if (rsp_field_end && rsp_ws_overflow) overflow_fields++;
         if (expected_tokens.size() == 0) begin
            mismatches++;
            $display("%0t unexpected transaction: out_byte %02h has_byte %0b field_end %0b",
                     $time, rsp_out_byte, rsp_has_byte, rsp_field_end);
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               mismatches++;
               $display("%0t out_byte: expected %02h, actual %02h",
                        $time, want.out_byte, rsp_out_byte);
            end
            if (rsp_has_byte !== want.has_byte) begin
               mismatches++;
               $display("%0t has_byte: expected %0b, actual %0b",
                        $time, want.has_byte, rsp_has_byte);
            end
            if (rsp_field_end !== want.field_end) begin
               mismatches++;
               $display("%0t field_end: expected %0b, actual %0b",
                        $time, want.field_end, rsp_field_end);
            end
            if (rsp_ws_overflow !== want.ws_overflow) begin
               mismatches++;
               $display("%0t ws_overflow: expected %0b, actual %0b",
                        $time, want.ws_overflow, rsp_ws_overflow);
            end
            if (rsp_last !== want.last) begin
               mismatches++;
               $display("%0t last: expected %0b, actual %0b", $time, want.last, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t no transaction for %0d cycles, %0d responses outstanding",
                  $time, QUIET_LIMIT, expected_tokens.size());
         $display("[csv_field_tokenizer] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_empty_fields();
      test_blank_handling();
      test_quoted_fields();
      test_stream_end();
      test_blank_overflow();
      test_random_records(0, 0, 30);
      test_random_records(62, 0, 30);
      test_random_records(0, 62, 30);
      test_random_records(14, 14, 30);
      test_backpressure();

      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses, closing %0d fields.",
               requests_sent, responses_seen, fields_closed);
      $display("%0d fields dropped blanks; idling mixes and a long response stall ran.",
               overflow_fields);
      if (mismatches == 0) begin
         $display("[csv_field_tokenizer] OK");
      end else begin
         $display("[csv_field_tokenizer] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
